// ===== rtl/escaped_frame_receiver_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the escaped frame receiver
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_RECEIVER_DEFINES_SVH
`define ESCAPED_FRAME_RECEIVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("escaped_frame_receiver: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define EFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("escaped_frame_receiver: next-cycle check failed");

// The consequent must hold later than the antecedent, not in the same cycle.
`define EFR_ASSERT_LATER2(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("escaped_frame_receiver: two-cycle check failed");

`endif

// ===== rtl/efr_pkg.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver package
// Buffer sizing, reset values, codes and shared types.
// ----------------------------------------------------------------------------
package efr_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int LEN_W        = 9;
  localparam int WIDE_W       = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  localparam logic [7:0] HEADER_RESET = 8'hff;
  localparam logic [7:0] TAIL_RESET   = 8'hfe;
  localparam logic [7:0] ESCAPE_RESET = 8'hfc;

  typedef enum logic [1:0] {
    CFG_HEADER = 2'd0,
    CFG_TAIL   = 2'd1,
    CFG_ESCAPE = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_READ    = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_IDLE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_DATA = 2'd1,
    PH_ESC  = 2'd2,
    PH_HELD = 2'd3
  } phase_t;

  typedef struct packed {
    logic             frame_ready;
    logic [LEN_W-1:0] frame_length;
    logic             overflow;
    logic             read_hit;
  } efr_status_t;

endpackage

// ===== rtl/efr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module efr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/escaped_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver
// Recovers one byte-stuffed frame into a payload buffer and serves reads.
// ----------------------------------------------------------------------------
// Channel  Direction  Word
// in_      slave      tuser: kind; tdata: rx_byte, read_index
// out_     master     tdata: frame_ready, frame_length, read_data, overflow
// cfg_     write      cfg_index selects header, tail or escape byte
//
// One word is accepted per cycle unless a stalled output holds the result
// stage; its result goes through the result stage to the output register.
// The payload buffer is read in the accept cycle and its data taken on s1_move.
// Reset clears phase, count and flag at once; the buffer needs no clearing.
// A stalled output holds the result stage, and in_tready drops until it moves.
// ----------------------------------------------------------------------------
module escaped_frame_receiver
  import efr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // rx_byte [7:0], read_index [15:8]
  input  logic [1:0]  in_tuser,   // kind [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // frame_ready [0], frame_length [9:1],
                                  // read_data [17:10], overflow [18], zero fill
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0]       header_r, tail_r, escape_r;
  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;

  logic             s1_valid_r;
  efr_status_t      s1_status_r, s1_status_nxt;
  logic             out_valid_r;
  logic [23:0]      out_data_r;

  logic             accept, s1_move;
  kind_t            kind;
  logic [7:0]       rx_byte, read_index;
  logic             store_req, do_store, room;
  logic             mem_we, mem_re;
  logic [7:0]       mem_rdata;
  logic [WIDE_W-1:0] idx_ext, count_ext, len_ext;

  assign kind       = kind_t'(in_tuser);
  assign rx_byte    = in_tdata[7:0];
  assign read_index = in_tdata[15:8];

  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RESET;
      tail_r   <= TAIL_RESET;
      escape_r <= ESCAPE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_HEADER: header_r <= cfg_wdata;
        CFG_TAIL:   tail_r   <= cfg_wdata;
        CFG_ESCAPE: escape_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (kind)
        KIND_BYTE: begin
          unique case (phase_r)
            PH_HUNT: if (rx_byte == header_r) phase_nxt = PH_DATA;
            PH_DATA: begin
              priority if (rx_byte == escape_r) phase_nxt = PH_ESC;
              else if (rx_byte == header_r)     phase_nxt = PH_DATA;
              else if (rx_byte == tail_r)       phase_nxt = PH_HELD;
              else                              phase_nxt = PH_DATA;
            end
            PH_ESC:  phase_nxt = PH_DATA;
            PH_HELD: phase_nxt = PH_HELD;
            default: phase_nxt = phase_r;
          endcase
        end
        KIND_RELEASE: phase_nxt = PH_HUNT;
        default:      phase_nxt = phase_r;
      endcase
    end
  end

  assign room = count_r < CNT_W'(BUFFER_DEPTH);

  always_comb begin
    logic restart;
    restart   = 1'b0;
    store_req = 1'b0;
    if (accept && kind == KIND_BYTE) begin
      unique case (phase_r)
        PH_HUNT: restart = (rx_byte == header_r);
        PH_DATA: begin
          restart   = (rx_byte != escape_r) && (rx_byte == header_r);
          store_req = (rx_byte != escape_r) && (rx_byte != header_r) &&
                      (rx_byte != tail_r);
        end
        PH_ESC:  store_req = 1'b1;
        default: ;
      endcase
    end
    do_store  = store_req && room;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (restart) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (do_store) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (store_req) begin
      ovf_nxt = 1'b1;
    end
  end

  assign idx_ext   = WIDE_W'(read_index);
  assign count_ext = WIDE_W'(count_r);
  assign len_ext   = WIDE_W'(count_nxt);
  assign mem_we    = do_store;
  assign mem_re    = accept && (kind == KIND_READ) && (idx_ext < count_ext);

  always_comb begin
    s1_status_nxt.frame_ready  = (phase_nxt == PH_HELD);
    s1_status_nxt.frame_length = len_ext[LEN_W-1:0];
    s1_status_nxt.overflow     = ovf_nxt;
    s1_status_nxt.read_hit     = mem_re;
  end

  efr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (rx_byte),
    .re    (mem_re),
    .raddr (idx_ext[ADDR_W-1:0]),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= s1_status_nxt;
    end
    if (s1_move) begin
      out_data_r <= {5'd0, s1_status_r.overflow,
                     s1_status_r.read_hit ? mem_rdata : 8'd0,
                     s1_status_r.frame_length, s1_status_r.frame_ready};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/efr_checker.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver checker
// Port-level checks on latency, status consistency and output stalls.
// ----------------------------------------------------------------------------
`include "escaped_frame_receiver_defines.svh"

module efr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  `EFR_ASSERT_LATER2(a_result_follows, in_tvalid && in_tready, out_tvalid)
  `EFR_ASSERT_NOW(a_length_bound, out_tvalid, out_tdata[9:1] <= 9'd256)
  `EFR_ASSERT_NOW(a_overflow_full, out_tvalid && out_tdata[18], out_tdata[9:1] == 9'd256)
  `EFR_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind escaped_frame_receiver efr_checker u_efr_checker (.*);
